FILE: rtl/v3a_pkg.sv
package v3a_pkg;

	localparam logic [2:0] OP_ADD   = 3'd0;
	localparam logic [2:0] OP_SUB   = 3'd1;
	localparam logic [2:0] OP_CROSS = 3'd2;
	localparam logic [2:0] OP_DOT   = 3'd3;
	localparam logic [2:0] OP_NORM  = 3'd4;

	typedef enum logic [2:0] {
		CLS_ADDSUB,
		CLS_CROSS,
		CLS_DOT,
		CLS_NORM,
		CLS_NULL
	} cls_t;

	typedef struct packed {
		logic        [2:0]  opcode;
		logic signed [31:0] a_x;
		logic signed [31:0] a_y;
		logic signed [31:0] a_z;
		logic signed [31:0] a_w;
		logic signed [31:0] b_x;
		logic signed [31:0] b_y;
		logic signed [31:0] b_z;
	} in_t;

	typedef struct packed {
		logic signed [31:0] r_x;
		logic signed [31:0] r_y;
		logic signed [31:0] r_z;
		logic signed [31:0] r_w;
		logic signed [31:0] scalar;
		logic               saturated;
		logic               zero_length;
	} out_t;

	typedef struct packed {
		cls_t cls;
		in_t  item;
	} q_entry_t;

	typedef struct packed {
		logic               flag;
		logic signed [31:0] val;
	} sat_t;

	localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
	localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

	function automatic sat_t sat32(input logic signed [65:0] v);
		sat_t r;
		if (v > SAT_MAX) begin
			r.flag = 1'b1;
			r.val  = 32'sh7fffffff;
		end else if (v < SAT_MIN) begin
			r.flag = 1'b1;
			r.val  = 32'sh80000000;
		end else begin
			r.flag = 1'b0;
			r.val  = v[31:0];
		end
		return r;
	endfunction

	function automatic logic signed [65:0] sx66(input logic signed [63:0] v);
		return $signed({{2{v[63]}}, v});
	endfunction

endpackage

FILE: rtl/vector3_alu_top.sv
// Three-component vector unit on signed fixed-point words with FRAC_BITS fraction bits.
// Input side is a queue: a word is taken on a rising edge with push high and full low.
// Result side is a queue: the oldest result sits on result while empty is low and is
// taken on a rising edge with pop high and empty low. Every input word gives one result.
// A front queue holds accepted words and tags each with its operation class; the back
// end drains that queue in order. Add, subtract, cross, dot and unused opcodes go
// through a two-stage multiply and combine pipeline at one word per cycle while no
// normalize word is running and the result queue has room for every word in flight.
// Normalize runs in a single iterative unit: it squares the components, sums them,
// takes the square root and then runs the three parallel divisions; the back end
// holds while the unit is busy on a normalize word.
// The back end issues only while the result queue has room for every word in flight,
// so a stalled receiver fills the result queue, then the front queue, then raises full.
// Results always leave in acceptance order.
// Reset is asynchronous and active low; it empties both queues and idles the unit.
module vector3_alu_top import v3a_pkg::*; #(
	parameter int FRAC_BITS = 16,
	parameter int IN_DEPTH  = 4,
	parameter int OUT_DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  in_t  item,
	output logic empty,
	input  logic pop,
	output out_t result
);

	q_entry_t head;
	logic     head_valid;
	logic     head_take;

	v3a_front #(
		.DEPTH(IN_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.head      (head),
		.head_valid(head_valid),
		.head_take (head_take)
	);

	v3a_back #(
		.FRAC_BITS(FRAC_BITS),
		.OUT_DEPTH(OUT_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.head_valid(head_valid),
		.head_take (head_take),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule

FILE: rtl/v3a_fifo.sv
module v3a_fifo import v3a_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic [WIDTH-1:0]             din,
	input  logic                         pop,
	output logic                         empty,
	output logic [WIDTH-1:0]             dout,
	output logic [$clog2(DEPTH+1)-1:0]   count
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_q;
	logic [AW-1:0]    rd_q;
	logic [CW-1:0]    cnt_q;
	logic             wr;
	logic             rd;

	assign full  = cnt_q == CW'(DEPTH);
	assign empty = cnt_q == '0;
	assign wr    = push && !full;
	assign rd    = pop && !empty;
	assign dout  = mem_q[rd_q];
	assign count = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (rd) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_q] <= din;
		end
	end

endmodule

FILE: rtl/v3a_front.sv
module v3a_front import v3a_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	output logic     full,
	input  in_t      item,
	output q_entry_t head,
	output logic     head_valid,
	input  logic     head_take
);

	q_entry_t entry;
	logic     q_empty;

	always_comb begin
		entry.item = item;
		case (item.opcode)
			OP_ADD, OP_SUB: entry.cls = CLS_ADDSUB;
			OP_CROSS:       entry.cls = CLS_CROSS;
			OP_DOT:         entry.cls = CLS_DOT;
			OP_NORM:        entry.cls = CLS_NORM;
			default:        entry.cls = CLS_NULL;
		endcase
	end

	v3a_fifo #(
		.WIDTH($bits(q_entry_t)),
		.DEPTH(DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.full  (full),
		.din   (entry),
		.pop   (head_take),
		.empty (q_empty),
		.dout  (head),
		.count ()
	);

	assign head_valid = !q_empty;

endmodule

FILE: rtl/v3a_norm.sv
module v3a_norm import v3a_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  in_t  item,
	output logic busy,
	output logic done,
	output out_t res
);

	localparam int NW = 32 + FRAC_BITS;
	localparam int CW = $clog2(NW + 1);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_SQ   = 6'b000010,
		ST_SUM  = 6'b000100,
		ST_ROOT = 6'b001000,
		ST_DIV  = 6'b010000,
		ST_FIN  = 6'b100000
	} nst_t;

	nst_t                     st_q;
	logic [CW-1:0]            cnt_q;
	logic signed [2:0][31:0]  v_q;
	logic signed [31:0]       w_q;
	logic signed [2:0][63:0]  sq_q;
	logic [63:0]              n_q;
	logic [63:0]              root_q;
	logic [63:0]              bit_q;
	logic [2:0][NW-1:0]       num_q;
	logic [2:0][31:0]         rem_q;
	logic [2:0][NW-1:0]       quo_q;
	logic [63:0]              trial;
	logic [31:0]              den;
	logic                     zl;

	assign trial = root_q + bit_q;
	assign den   = root_q[31:0];
	assign zl    = den == '0;
	assign busy  = st_q != ST_IDLE;
	assign done  = st_q == ST_FIN;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			case (st_q)
				ST_IDLE: if (start) st_q <= ST_SQ;
				ST_SQ:   st_q <= ST_SUM;
				ST_SUM: begin
					st_q  <= ST_ROOT;
					cnt_q <= CW'(31);
				end
				ST_ROOT: begin
					if (cnt_q == '0) begin
						st_q  <= ST_DIV;
						cnt_q <= CW'(NW - 1);
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						st_q <= ST_FIN;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_FIN:  st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		logic [32:0] rn;
		logic [31:0] mag;
		logic        ge;
		case (st_q)
			ST_IDLE: begin
				if (start) begin
					v_q[0] <= item.a_x;
					v_q[1] <= item.a_y;
					v_q[2] <= item.a_z;
					w_q    <= item.a_w;
					for (int k = 0; k < 3; k++) begin
						rem_q[k] <= '0;
						quo_q[k] <= '0;
					end
					mag = item.a_x[31] ? (~item.a_x + 1'b1) : item.a_x;
					num_q[0] <= {mag, {FRAC_BITS{1'b0}}};
					mag = item.a_y[31] ? (~item.a_y + 1'b1) : item.a_y;
					num_q[1] <= {mag, {FRAC_BITS{1'b0}}};
					mag = item.a_z[31] ? (~item.a_z + 1'b1) : item.a_z;
					num_q[2] <= {mag, {FRAC_BITS{1'b0}}};
				end
			end
			ST_SQ: begin
				for (int k = 0; k < 3; k++) begin
					sq_q[k] <= $signed(v_q[k]) * $signed(v_q[k]);
				end
			end
			ST_SUM: begin
				n_q    <= sq_q[0] + sq_q[1] + sq_q[2];
				root_q <= '0;
				bit_q  <= 64'd1 << 62;
			end
			ST_ROOT: begin
				if (n_q >= trial) begin
					n_q    <= n_q - trial;
					root_q <= (root_q >> 1) + bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			ST_DIV: begin
				for (int k = 0; k < 3; k++) begin
					rn = {rem_q[k], num_q[k][NW-1]};
					ge = rn >= {1'b0, den};
					rem_q[k] <= ge ? 32'(rn - {1'b0, den}) : rn[31:0];
					num_q[k] <= num_q[k] << 1;
					quo_q[k] <= {quo_q[k][NW-2:0], ge};
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		sat_t                     s [3];
		logic signed [65:0]       q;
		for (int k = 0; k < 3; k++) begin
			q = $signed({{(66 - NW){1'b0}}, quo_q[k]});
			s[k] = sat32(v_q[k][31] ? -q : q);
		end
		res.r_w         = w_q;
		res.scalar      = '0;
		res.zero_length = zl;
		if (zl) begin
			res.r_x       = v_q[0];
			res.r_y       = v_q[1];
			res.r_z       = v_q[2];
			res.saturated = 1'b0;
		end else begin
			res.r_x       = s[0].val;
			res.r_y       = s[1].val;
			res.r_z       = s[2].val;
			res.saturated = s[0].flag | s[1].flag | s[2].flag;
		end
	end

endmodule

FILE: rtl/v3a_back.sv
module v3a_back import v3a_pkg::*; #(
	parameter int FRAC_BITS = 16,
	parameter int OUT_DEPTH = 4
) (
	input  logic     clk,
	input  logic     arst_n,
	input  q_entry_t head,
	input  logic     head_valid,
	output logic     head_take,
	output logic     empty,
	input  logic     pop,
	output out_t     result
);

	localparam int OCW = $clog2(OUT_DEPTH + 1);

	logic                    v_s1;
	cls_t                    cls_s1;
	logic signed [2:0][32:0] sum_s1;
	logic signed [5:0][63:0] p_s1;
	logic                    v_s2;
	out_t                    res_s2;

	logic [OCW-1:0]          out_cnt;
	logic                    out_full;
	logic [OCW:0]            inflight;
	logic                    pipe_issue;
	logic                    norm_start;
	logic                    norm_busy;
	logic                    norm_done;
	out_t                    norm_res;
	out_t                    out_din;
	logic                    out_push;

	logic signed [2:0][32:0] sum_c;
	logic signed [5:0][31:0] ma;
	logic signed [5:0][31:0] mb;
	out_t                    res_c;
	logic signed [31:0]      one_w;

	assign one_w    = 32'(64'd1 << FRAC_BITS);
	assign inflight = (OCW + 1)'(out_cnt) + (OCW + 1)'(v_s1) + (OCW + 1)'(v_s2);

	assign pipe_issue = head_valid && head.cls != CLS_NORM && !norm_busy
		&& inflight < (OCW + 1)'(OUT_DEPTH);
	assign norm_start = head_valid && head.cls == CLS_NORM && !norm_busy
		&& !v_s1 && !v_s2 && !out_full;
	assign head_take  = pipe_issue || norm_start;

	always_comb begin
		in_t it;
		it = head.item;
		if (it.opcode == OP_SUB) begin
			sum_c[0] = $signed({it.a_x[31], it.a_x}) - $signed({it.b_x[31], it.b_x});
			sum_c[1] = $signed({it.a_y[31], it.a_y}) - $signed({it.b_y[31], it.b_y});
			sum_c[2] = $signed({it.a_z[31], it.a_z}) - $signed({it.b_z[31], it.b_z});
		end else begin
			sum_c[0] = $signed({it.a_x[31], it.a_x}) + $signed({it.b_x[31], it.b_x});
			sum_c[1] = $signed({it.a_y[31], it.a_y}) + $signed({it.b_y[31], it.b_y});
			sum_c[2] = $signed({it.a_z[31], it.a_z}) + $signed({it.b_z[31], it.b_z});
		end
		if (head.cls == CLS_DOT) begin
			ma[0] = it.a_x; mb[0] = it.b_x;
			ma[1] = '0;     mb[1] = '0;
			ma[2] = it.a_y; mb[2] = it.b_y;
			ma[3] = '0;     mb[3] = '0;
			ma[4] = it.a_z; mb[4] = it.b_z;
			ma[5] = '0;     mb[5] = '0;
		end else begin
			ma[0] = it.a_y; mb[0] = it.b_z;
			ma[1] = it.a_z; mb[1] = it.b_y;
			ma[2] = it.a_z; mb[2] = it.b_x;
			ma[3] = it.a_x; mb[3] = it.b_z;
			ma[4] = it.a_x; mb[4] = it.b_y;
			ma[5] = it.a_y; mb[5] = it.b_x;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= pipe_issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_issue) begin
			cls_s1 <= head.cls;
			sum_s1 <= sum_c;
			for (int k = 0; k < 6; k++) begin
				p_s1[k] <= $signed(ma[k]) * $signed(mb[k]);
			end
		end
		if (v_s1) begin
			res_s2 <= res_c;
		end
	end

	always_comb begin
		sat_t               s [3];
		logic signed [65:0] d [3];
		logic signed [65:0] dot;
		res_c = '0;
		s     = '{default: '0};
		for (int k = 0; k < 3; k++) begin
			d[k] = sx66(p_s1[2*k]) - sx66(p_s1[2*k+1]);
			d[k] = d[k] >>> FRAC_BITS;
		end
		dot = sx66(p_s1[0]) + sx66(p_s1[2]) + sx66(p_s1[4]);
		dot = dot >>> FRAC_BITS;
		case (cls_s1)
			CLS_ADDSUB: begin
				for (int k = 0; k < 3; k++) begin
					s[k] = sat32($signed({{33{sum_s1[k][32]}}, sum_s1[k]}));
				end
				res_c.r_x       = s[0].val;
				res_c.r_y       = s[1].val;
				res_c.r_z       = s[2].val;
				res_c.r_w       = one_w;
				res_c.saturated = s[0].flag | s[1].flag | s[2].flag;
			end
			CLS_CROSS: begin
				for (int k = 0; k < 3; k++) begin
					s[k] = sat32(d[k]);
				end
				res_c.r_x       = s[0].val;
				res_c.r_y       = s[1].val;
				res_c.r_z       = s[2].val;
				res_c.r_w       = one_w;
				res_c.saturated = s[0].flag | s[1].flag | s[2].flag;
			end
			CLS_DOT: begin
				s[0] = sat32(dot);
				res_c.scalar    = s[0].val;
				res_c.r_w       = one_w;
				res_c.saturated = s[0].flag;
			end
			default: res_c = '0;
		endcase
	end

	v3a_norm #(
		.FRAC_BITS(FRAC_BITS)
	) u_norm (
		.clk   (clk),
		.arst_n(arst_n),
		.start (norm_start),
		.item  (head.item),
		.busy  (norm_busy),
		.done  (norm_done),
		.res   (norm_res)
	);

	assign out_push = v_s2 || norm_done;
	assign out_din  = norm_done ? norm_res : res_s2;

	v3a_fifo #(
		.WIDTH($bits(out_t)),
		.DEPTH(OUT_DEPTH)
	) u_out (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (out_push),
		.full  (out_full),
		.din   (out_din),
		.pop   (pop),
		.empty (empty),
		.dout  (result),
		.count (out_cnt)
	);

	// The normalize unit and the product pipeline never finish in the same cycle.
	assert property (@(posedge clk) disable iff (!arst_n) !(v_s2 && norm_done))
		else $error("normalize result collides with pipeline result");

	// Credits must keep the result queue from overflowing.
	assert property (@(posedge clk) disable iff (!arst_n) !(out_push && out_full))
		else $error("result queue written while full");

	// A normalize word starts only behind a drained pipeline.
	assert property (@(posedge clk) disable iff (!arst_n) norm_start |-> !v_s1 && !v_s2)
		else $error("normalize started with pipeline busy");

	assert property (@(posedge clk) disable iff (!arst_n) norm_start |=> norm_busy)
		else $error("normalize unit did not start");

endmodule

FILE: dv/vector3_alu_top_tb.sv
`timescale 1ns / 100ps

module vector3_alu_top_tb import v3a_pkg::*;;

	localparam int FRAC = 16;
	localparam int WATCHDOG_LIMIT = 20000;

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	in_t  item;
	logic empty;
	logic pop;
	out_t result;

	out_t expected_results[$];
	int   mismatches;
	int   idle_cycles;
	bit   hold_off;
	int   pop_mode;

	vector3_alu_top #(.FRAC_BITS(FRAC)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.empty(empty),
		.pop(pop),
		.result(result)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic logic signed [31:0] clip(input logic signed [127:0] v, inout bit flag);
		if (v > 128'sd2147483647) begin
			flag = 1'b1;
			return 32'sh7fffffff;
		end
		if (v < -128'sd2147483648) begin
			flag = 1'b1;
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	function automatic logic [63:0] floor_root(input logic [127:0] n);
		logic [127:0] lo;
		logic [127:0] hi;
		logic [127:0] mid;
		lo = 0;
		hi = 128'h1_0000_0000_0000;
		while (lo < hi) begin
			mid = (lo + hi + 1) >> 1;
			if (mid * mid <= n) lo = mid;
			else hi = mid - 1;
		end
		return lo[63:0];
	endfunction

	function automatic out_t vector_result(input in_t w);
		out_t r;
		bit f;
		logic signed [127:0] ax, ay, az, bx, by, bz, sq, mag, q;
		logic [63:0] len;
		r = '0;
		f = 1'b0;
		ax = w.a_x; ay = w.a_y; az = w.a_z;
		bx = w.b_x; by = w.b_y; bz = w.b_z;
		case (w.opcode)
			OP_ADD: begin
				r.r_x = clip(ax + bx, f); r.r_y = clip(ay + by, f); r.r_z = clip(az + bz, f);
				r.r_w = 32'sd1 <<< FRAC;
			end
			OP_SUB: begin
				r.r_x = clip(ax - bx, f); r.r_y = clip(ay - by, f); r.r_z = clip(az - bz, f);
				r.r_w = 32'sd1 <<< FRAC;
			end
			OP_CROSS: begin
				r.r_x = clip((ay * bz - az * by) >>> FRAC, f);
				r.r_y = clip((az * bx - ax * bz) >>> FRAC, f);
				r.r_z = clip((ax * by - ay * bx) >>> FRAC, f);
				r.r_w = 32'sd1 <<< FRAC;
			end
			OP_DOT: begin
				r.scalar = clip((ax * bx + ay * by + az * bz) >>> FRAC, f);
				r.r_w = 32'sd1 <<< FRAC;
			end
			OP_NORM: begin
				sq = ax * ax + ay * ay + az * az;
				len = floor_root(sq);
				r.r_w = w.a_w;
				if (len == 0) begin
					r.r_x = w.a_x; r.r_y = w.a_y; r.r_z = w.a_z;
					r.zero_length = 1'b1;
				end else begin
					mag = ((ax < 0) ? -ax : ax) <<< FRAC;
					q = mag / $signed({64'd0, len});
					r.r_x = clip((ax < 0) ? -q : q, f);
					mag = ((ay < 0) ? -ay : ay) <<< FRAC;
					q = mag / $signed({64'd0, len});
					r.r_y = clip((ay < 0) ? -q : q, f);
					mag = ((az < 0) ? -az : az) <<< FRAC;
					q = mag / $signed({64'd0, len});
					r.r_z = clip((az < 0) ? -q : q, f);
				end
			end
			default: ;
		endcase
		r.saturated = f;
		return r;
	endfunction

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return 32'h0;
			3: return $urandom_range(0, 1) ? 32'h00010000 : 32'hffff0000;
			4: return $signed($urandom_range(0, 65535)) - 32768;
			5: return $signed($urandom_range(0, 32'h00ffffff)) - 32'h00800000;
			default: return $urandom;
		endcase
	endfunction

	// Push stays high after a word so that the next word can follow without a gap.
	task automatic send_word(input in_t w);
		push <= 1'b1;
		item <= w;
		@(posedge clk);
		while (full) @(posedge clk);
		expected_results.push_back(vector_result(w));
		@(negedge clk);
	endtask

	task automatic send_gap();
		int n;
		n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
		if (n > 0) begin
			push <= 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	function automatic in_t make_word(input logic [2:0] op, input logic [31:0] v[7]);
		in_t w;
		w.opcode = op;
		w.a_x = v[0]; w.a_y = v[1]; w.a_z = v[2]; w.a_w = v[3];
		w.b_x = v[4]; w.b_y = v[5]; w.b_z = v[6];
		return w;
	endfunction

	task automatic test_directed();
		logic [31:0] v[7];
		for (int op = 0; op < 8; op++) begin
			v = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h12345678,
				32'h7fffffff, 32'h7fffffff, 32'h7fffffff};
			send_word(make_word(op[2:0], v));
			v = '{32'h80000000, 32'h7fffffff, 32'h80000000, 32'hffffffff,
				32'h7fffffff, 32'h80000000, 32'h7fffffff};
			send_word(make_word(op[2:0], v));
		end
		v = '{0, 0, 0, 32'h5a5a5a5a, 32'h1, 32'h2, 32'h3};
		send_word(make_word(OP_NORM, v));
		v = '{32'h1, 0, 0, 32'h0, 0, 0, 0};
		send_word(make_word(OP_NORM, v));
		v = '{32'h00010000, 32'h00010000, 32'h00010000, 32'h00010000, 0, 0, 0};
		send_word(make_word(OP_NORM, v));
		v = '{32'hffff0000, 32'h00020000, 32'h0, 0, 32'h00010000, 32'h00010000, 32'h1};
		send_word(make_word(OP_CROSS, v));
		send_word(make_word(OP_DOT, v));
		v = '{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0};
		send_word(make_word(OP_NORM, v));
	endtask

	task automatic test_random(input int count);
		logic [31:0] v[7];
		logic [2:0] op;
		int burst;
		while (count > 0) begin
			burst = $urandom_range(1, 20);
			while (burst > 0 && count > 0) begin
				foreach (v[i]) v[i] = pick_value();
				op = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7))
					: 3'($urandom_range(0, 4));
				send_word(make_word(op, v));
				burst--;
				count--;
			end
			send_gap();
		end
	endtask

	always @(negedge clk) begin
		case (pop_mode)
			0: pop <= 1'b1;
			1: pop <= ($urandom_range(0, 3) != 0);
			default: pop <= ($urandom_range(0, 3) == 0);
		endcase
		if ($urandom_range(0, 99) == 0) pop_mode = $urandom_range(0, 2);
	end

	always @(posedge clk) begin
		out_t exp_w;
		if (arst_n && pop && !empty) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result word %h", result);
			end else begin
				exp_w = expected_results.pop_front();
				if (result !== exp_w) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %h actual %h", exp_w, result);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || hold_off) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		item = '0;
		mismatches = 0;
		idle_cycles = 0;
		hold_off = 1'b1;
		pop_mode = 0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		hold_off = 1'b0;
		@(negedge clk);
		test_directed();
		test_random(1300);
		push <= 1'b0;
		while (expected_results.size() != 0) @(negedge clk);
		hold_off = 1'b1;
		repeat (200) @(negedge clk);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
